// ===== rtl/graph_depth_first_walker_macros.svh =====
// Assertion macros for the depth-first graph walker.
// Used by graph_depth_first_walker.sv; expects clk and rst_n in scope.
`ifndef GRAPH_DEPTH_FIRST_WALKER_MACROS_SVH
`define GRAPH_DEPTH_FIRST_WALKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define GDFW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define GDFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDFW_ASSERT_IMPLY(label, ante, cons, msg)
`define GDFW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/gdfw_pkg.sv =====
// Shared constants and codes for the depth-first graph walker.
// No dependencies; imported by the walker RTL.
`default_nettype none

package gdfw_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_DEGREE_DEF   = 16;
  localparam int MAX_RESULTS      = 16;

  localparam int VTX_W  = 4;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 5'd16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WALK   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/graph_depth_first_walker.sv =====
// Depth-first graph walker top level: sequencer, lists, stack and result port.
// Depends on gdfw_pkg, gdfw_ram and graph_depth_first_walker_macros.svh.
`default_nettype none

`include "graph_depth_first_walker_macros.svh"

// A request transfers at a clock edge where start is high and busy is low;
// busy then stays high until the request is finished, one request at a time.
// Results come out on out_*, each marked by out_valid for exactly
// one cycle; the receiver cannot stall them and must take every one. The
// final result of a request carries out_last. Add and remove give a single
// result; a walk gives one result per visited vertex (at most 16), in
// depth-first order. All edge lists sit in one RAM with a single read port
// and a registered read, and that port sets the pace of each request:
//   add:    range check and write.
//   remove: search of the list for the entry, then a shift of the entries behind it.
//   walk:   a read per edge leaving the visited vertices, and a pop per
//           visited vertex.
// Each result shows on the ports in the cycle after it is produced, so the
// last result of a request is on the ports in the first cycle of busy low.
// Request type 3 is taken and ignored: busy does not rise.
// vertex_count (cfg_wr_data) may be written only while busy is low.

module graph_depth_first_walker import gdfw_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [VTX_W-1:0]  in_source_vertex,
  input  logic [VTX_W-1:0]  in_dest_vertex,
  input  logic [VTX_W-1:0]  in_start_vertex,
  // result channel
  output logic              out_valid,
  output logic [VTX_W-1:0]  out_visited_vertex,
  output logic              out_last,
  output logic [STAT_W-1:0] out_status
);

  // vertex index, list index, list count and stack pointer widths
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int SPW = $clog2(MAX_VERTICES + 1);
  localparam int AW  = VW + DW;
  localparam int RAM_DEPTH = 1 << AW;
  // effective vertex count width: holds both the register and the max
  localparam int NW  = (SPW > CFG_W) ? SPW : CFG_W;
  localparam int KW  = $clog2(MAX_RESULTS + 1);

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CHECK     = 8'b0000_0010,  // range check, add, walk setup
    S_FIND_RD   = 8'b0000_0100,  // issue read of list entry idx
    S_FIND_CHK  = 8'b0000_1000,  // compare entry with the target
    S_SHIFT_RD  = 8'b0001_0000,  // issue read of entry idx+1
    S_SHIFT_WR  = 8'b0010_0000,  // write it back at idx
    S_WALK_TOP  = 8'b0100_0000,  // look at top of stack
    S_WALK_EDGE = 8'b1000_0000   // examine the fetched edge target
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_vc_r;

  // latched request
  logic [REQ_W-1:0] req_r;
  logic [VTX_W-1:0] src_r, dst_r, stv_r;

  // list index for remove search and shift
  logic [CW-1:0] idx_r, idx_nxt;

  // per-vertex list fill, visited marks
  logic [CW-1:0]           cnt_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_r;

  // walk stack: vertex and next-edge index per level
  logic [VTX_W-1:0] stk_v_r [MAX_VERTICES];
  logic [CW-1:0]    stk_i_r [MAX_VERTICES];
  logic [SPW-1:0]   sp_r, sp_nxt;

  // held-back visit: released once the next visit or the end is known
  logic [VTX_W-1:0] pend_r, pend_nxt;
  logic [KW-1:0]    k_r, k_nxt;

  // result register
  logic              ov_r, ov_nxt;
  logic [VTX_W-1:0]  ovtx_r, ovtx_nxt;
  logic              olast_r, olast_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;

  // array write strobes
  logic             cnt_we;
  logic [VW-1:0]    cnt_wa;
  logic [CW-1:0]    cnt_wd;
  logic             stk_we;
  logic [VW-1:0]    stk_wa;
  logic [VTX_W-1:0] stk_wv;
  logic [CW-1:0]    stk_wi;
  logic             vis_clr, vis_set;
  logic [VW-1:0]    vis_sa;

  // edge RAM port
  logic             ram_we;
  logic [AW-1:0]    ram_wa, ram_ra;
  logic [VTX_W-1:0] ram_wd, ram_rd;

  // decoded views
  logic [NW-1:0]    n_eff;
  logic             src_ok, dst_ok, stv_ok;
  logic [VW-1:0]    top_a;
  logic [VTX_W-1:0] top_v;
  logic [CW-1:0]    top_i;
  logic [VW-1:0]    cnt_a;
  logic [CW-1:0]    cnt_sel;
  logic             cnt_full;
  logic [CW-1:0]    idx_p1;
  logic             d_new;
  logic [MAX_VERTICES-1:0] vis_upd;

  gdfw_ram #(
    .WIDTH (VTX_W),
    .DEPTH (RAM_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  // vertex_count clipped to the table size
  assign n_eff = (NW'(cfg_vc_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cfg_vc_r);
  assign src_ok = NW'(src_r) < n_eff;
  assign dst_ok = NW'(dst_r) < n_eff;
  assign stv_ok = NW'(stv_r) < n_eff;

  assign top_a = VW'(sp_r - SPW'(1));
  assign top_v = stk_v_r[top_a];
  assign top_i = stk_i_r[top_a];

  // single count read: the top vertex while walking, else the source
  assign cnt_a    = (state_r == S_WALK_TOP) ? VW'(top_v) : VW'(src_r);
  assign cnt_sel  = cnt_r[cnt_a];
  assign cnt_full = cnt_sel >= CW'(MAX_DEGREE);
  assign idx_p1   = idx_r + CW'(1);

  // fetched target is in range and not yet seen (stale edges drop out here)
  assign d_new = (NW'(ram_rd) < n_eff) && !vis_r[VW'(ram_rd)];

  // marks after this cycle: optional clear, then at most one bit set
  assign vis_upd = (vis_clr ? '0 : vis_r) |
                   ({{(MAX_VERTICES-1){1'b0}}, vis_set} << vis_sa);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sp_nxt    = sp_r;
    pend_nxt  = pend_r;
    k_nxt     = k_r;
    ov_nxt    = 1'b0;
    ovtx_nxt  = '0;
    olast_nxt = 1'b0;
    ostat_nxt = ST_OK;
    cnt_we    = 1'b0;
    cnt_wa    = VW'(src_r);
    cnt_wd    = cnt_sel;
    stk_we    = 1'b0;
    stk_wa    = top_a;
    stk_wv    = top_v;
    stk_wi    = '0;
    vis_clr   = 1'b0;
    vis_set   = 1'b0;
    vis_sa    = VW'(ram_rd);
    ram_we    = 1'b0;
    ram_wa    = {VW'(src_r), DW'(idx_r)};
    ram_wd    = dst_r;
    ram_ra    = {VW'(src_r), DW'(idx_r)};

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start && (in_req_type inside {REQ_ADD, REQ_REMOVE, REQ_WALK})) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (req_r == REQ_WALK) begin
          if (!stv_ok) begin
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
            ostat_nxt = ST_RANGE;
            state_nxt = S_IDLE;
          end else begin
            // fresh marks, start vertex visited and pushed, its result held
            vis_clr   = 1'b1;
            vis_set   = 1'b1;
            vis_sa    = VW'(stv_r);
            pend_nxt  = stv_r;
            k_nxt     = KW'(1);
            stk_we    = 1'b1;
            stk_wa    = '0;
            stk_wv    = stv_r;
            stk_wi    = '0;
            sp_nxt    = SPW'(1);
            state_nxt = S_WALK_TOP;
          end
        end else if (!(src_ok && dst_ok)) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          ostat_nxt = ST_RANGE;
          state_nxt = S_IDLE;
        end else if (req_r == REQ_ADD) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (cnt_full) begin
            ostat_nxt = ST_FULL;
          end else begin
            ram_we = 1'b1;
            ram_wa = {VW'(src_r), DW'(cnt_sel)};
            cnt_we = 1'b1;
            cnt_wd = cnt_sel + CW'(1);
          end
        end else begin
          state_nxt = S_FIND_RD;
        end
      end

      S_FIND_RD: begin
        if (idx_r >= cnt_sel) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          ostat_nxt = ST_MISSING;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FIND_CHK;
        end
      end

      S_FIND_CHK: begin
        if (ram_rd == dst_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_FIND_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_p1 >= cnt_sel) begin
          cnt_we    = 1'b1;
          cnt_wd    = cnt_sel - CW'(1);
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_ra    = {VW'(src_r), DW'(idx_p1)};
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wd    = ram_rd;
        idx_nxt   = idx_p1;
        state_nxt = S_SHIFT_RD;
      end

      S_WALK_TOP: begin
        if (sp_r == '0) begin
          // stack empty: release the held visit as the final result
          ov_nxt    = 1'b1;
          ovtx_nxt  = pend_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (top_i >= cnt_sel) begin
          sp_nxt = sp_r - SPW'(1);
        end else begin
          ram_ra    = {VW'(top_v), DW'(top_i)};
          stk_we    = 1'b1;
          stk_wi    = top_i + CW'(1);
          state_nxt = S_WALK_EDGE;
        end
      end

      S_WALK_EDGE: begin
        state_nxt = S_WALK_TOP;
        if (d_new) begin
          vis_set = 1'b1;
          if (k_r < KW'(MAX_RESULTS)) begin
            ov_nxt   = 1'b1;
            ovtx_nxt = pend_r;
            pend_nxt = ram_rd;
            k_nxt    = k_r + KW'(1);
          end
          if (sp_r < SPW'(MAX_VERTICES)) begin
            stk_we = 1'b1;
            stk_wa = VW'(sp_r);
            stk_wv = ram_rd;
            stk_wi = '0;
            sp_nxt = sp_r + SPW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cfg_vc_r <= VERTEX_COUNT_RST;
      sp_r     <= '0;
      k_r      <= '0;
      ov_r     <= 1'b0;
      vis_r    <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        cfg_vc_r <= cfg_wr_data;
      end
      if (cnt_we) begin
        cnt_r[cnt_wa] <= cnt_wd;
      end
      if (vis_clr || vis_set) begin
        vis_r <= vis_upd;
      end
    end
  end

  // payload: request latch, walk stack, held visit, result fields
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_req_type;
      src_r <= in_source_vertex;
      dst_r <= in_dest_vertex;
      stv_r <= in_start_vertex;
    end
    if (stk_we) begin
      stk_v_r[stk_wa] <= stk_wv;
      stk_i_r[stk_wa] <= stk_wi;
    end
    idx_r   <= idx_nxt;
    pend_r  <= pend_nxt;
    ovtx_r  <= ovtx_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_visited_vertex = ovtx_r;
  assign out_last           = olast_r;
  assign out_status         = ostat_r;

  // error results always close their request
  `GDFW_ASSERT_IMPLY(a_err_is_last, out_valid && (out_status != ST_OK), out_last,
                     "error result without last")
  // a result that is not the last one belongs to a walk still running
  `GDFW_ASSERT_IMPLY(a_mid_busy, out_valid && !out_last, busy,
                     "intermediate result while idle")
  // after an intermediate result the walk either continues or closes
  `GDFW_ASSERT_NEXT(a_mid_follow, out_valid && !out_last,
                    busy || (out_valid && out_last),
                    "walk ended without a last result")

endmodule

`default_nettype wire

// ===== rtl/gdfw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gdfw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
